// ----- sv/db_record_column_decoder_macros.svh -----
// Assertion macros shared by the record column decoder.
`ifndef DB_RECORD_COLUMN_DECODER_MACROS_SVH
`define DB_RECORD_COLUMN_DECODER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DBRCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define DBRCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define DBRCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dbrcd_pkg.sv -----
// Types, constants and helper functions of the record column decoder.
package dbrcd_pkg;

	localparam int COL_W       = 6;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_TUSER_W = 4;

	// Varint byte layout.
	localparam logic [7:0] VI_LOW_MASK  = 8'h7F;
	localparam logic [7:0] VI_CONT      = 8'h80;
	localparam logic [3:0] VI_MAX_7BIT  = 4'd8;

	// Serial types with a special meaning.
	localparam logic [31:0] ST_NULL     = 32'd0;
	localparam logic [31:0] ST_INT48    = 32'd5;
	localparam logic [31:0] ST_INT64    = 32'd6;
	localparam logic [31:0] ST_FLOAT    = 32'd7;
	localparam logic [31:0] ST_ZERO     = 32'd8;
	localparam logic [31:0] ST_ONE      = 32'd9;
	localparam logic [31:0] ST_RES10    = 32'd10;
	localparam logic [31:0] ST_RES11    = 32'd11;
	localparam logic [31:0] ST_VAR_MIN  = 32'd12;

	typedef enum logic [2:0] {
		KIND_NULL     = 3'd0,
		KIND_INT      = 3'd1,
		KIND_FLOAT    = 3'd2,
		KIND_TEXT     = 3'd3,
		KIND_BLOB     = 3'd4,
		KIND_RESERVED = 3'd5,
		KIND_TRUNC    = 3'd6,
		KIND_EOR      = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		PH_HLEN  = 2'd0,
		PH_TYPES = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IN,
		ST_EXEC,
		ST_DRAIN_RD,
		ST_DRAIN_EV,
		ST_FIN,
		ST_TRUNC,
		ST_EOR
	} state_t;

	typedef struct packed {
		logic feed;
		logic clr;
	} varint_ctl_t;

	typedef struct packed {
		logic [4:0]  col;
		kind_t       kind;
		logic [63:0] value;
		logic [7:0]  data;
		logic        bv;
		logic        cd;
		logic        rd;
	} result_t;

	// Number of body bytes a serial type occupies.
	function automatic logic [31:0] body_len(input logic [31:0] t);
		logic [31:0] d;
		begin
			d = t - ST_VAR_MIN;
			if (t != ST_NULL && t < ST_INT48) begin
				body_len = t;
			end else if (t == ST_INT48) begin
				body_len = 32'd6;
			end else if (t == ST_INT64 || t == ST_FLOAT) begin
				body_len = 32'd8;
			end else if (t >= ST_VAR_MIN) begin
				body_len = {1'b0, d[31:1]};
			end else begin
				body_len = '0;
			end
		end
	endfunction

	// Sign-extends a big-endian integer of the given byte count.
	function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [3:0] nbytes);
		logic [63:0] r;
		begin
			case (nbytes)
				4'd1: r = {{56{v[7]}}, v[7:0]};
				4'd2: r = {{48{v[15]}}, v[15:0]};
				4'd3: r = {{40{v[23]}}, v[23:0]};
				4'd4: r = {{32{v[31]}}, v[31:0]};
				4'd6: r = {{16{v[47]}}, v[47:0]};
				default: r = v;
			endcase
			sign_ext = r;
		end
	endfunction

endpackage

// ----- sv/dbrcd_type_mem.sv -----
// Serial type store: one write port, one registered read port.
module dbrcd_type_mem #(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/dbrcd_varint.sv -----
// Varint accumulator with saturation of the header length and serial type.
module dbrcd_varint (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dbrcd_pkg::varint_ctl_t ctl,
	input  logic [7:0]            byte_in,
	output logic                  done,
	output logic [31:0]           hlen_sat,
	output logic [31:0]           type_sat
);

	import dbrcd_pkg::*;

	logic [63:0] accum_q;
	logic [3:0]  bytes_q;
	logic [63:0] acc_next;
	logic        ninth;

	// The ninth byte carries all eight bits and always closes the varint.
	assign ninth    = (bytes_q >= VI_MAX_7BIT);
	assign acc_next = ninth ? {accum_q[55:0], byte_in}
	                        : {accum_q[56:0], byte_in[6:0] & VI_LOW_MASK[6:0]};
	assign done     = ninth || ((byte_in & VI_CONT) == 8'h00);

	assign hlen_sat = (|acc_next[63:32]) ? 32'hFFFF_FFFF : acc_next[31:0];
	assign type_sat = (|acc_next[63:32]) ? {31'h7FFF_FFFF, acc_next[0]} : acc_next[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			bytes_q <= '0;
		end else if (ctl.clr || (ctl.feed && done)) begin
			accum_q <= '0;
			bytes_q <= '0;
		end else if (ctl.feed) begin
			accum_q <= acc_next;
			bytes_q <= bytes_q + 4'd1;
		end
	end

endmodule

// ----- sv/dbrcd_out_reg.sv -----
// Output register of the master-side stream.
module dbrcd_out_reg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  dbrcd_pkg::result_t                   res,
	output logic                                 free,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// column_index[4:0], int_value[68:5], data_byte[76:69], column_done[77], zero pad
	output logic [dbrcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// kind[2:0], byte_valid[3]
	output logic [dbrcd_pkg::OUT_TUSER_W-1:0]    m_tuser,
	output logic                                 m_tlast
);

	import dbrcd_pkg::*;

	result_t res_q;
	logic    valid_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, res_q.cd, res_q.data, res_q.value, res_q.col};
	assign m_tuser  = {res_q.bv, res_q.kind};
	assign m_tlast  = res_q.rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// ----- sv/db_record_column_decoder.sv -----
// Top level of the record column decoder: sequencer, record state and type store.
// Each record byte is accepted in ST_IN and decoded in ST_EXEC; s_tready is low while it decodes.
// A finished value or content byte passes through byte_q and the output register to m_tvalid.
// Moving to a new column reads its type in ST_DRAIN_RD and ST_DRAIN_EV, whether the column
// is loaded or emitted at once as zero-length, and ST_DRAIN_RD runs once more when none is left;
// record end goes ST_FIN, ST_TRUNC (one truncation result per column still to send), ST_EOR.
// Asynchronous reset returns the decoder to the header-length phase with no columns stored.
`include "db_record_column_decoder_macros.svh"

module db_record_column_decoder #(
	parameter int MAX_COLUMNS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// rec_byte[7:0]
	input  logic [7:0]                           s_tdata,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// column_index[4:0], int_value[68:5], data_byte[76:69], column_done[77], zero pad
	output logic [dbrcd_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// kind[2:0], byte_valid[3]
	output logic [dbrcd_pkg::OUT_TUSER_W-1:0]    m_tuser,
	output logic                                 m_tlast
);

	import dbrcd_pkg::*;

	localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam logic [COL_W-1:0] MAX_COLS = COL_W'(MAX_COLUMNS);

	state_t           state_q, state_d;
	phase_t           phase_q;
	logic [31:0]      header_length_q;
	logic [31:0]      byte_position_q;
	logic [COL_W-1:0] column_count_q;
	logic [COL_W-1:0] cur_col_q;
	logic [31:0]      body_rem_q;
	logic [63:0]      value_acc_q;
	logic             overflow_q;
	logic [31:0]      cur_type_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             trunc_byte_q;

	varint_ctl_t vctl;
	logic        v_done;
	logic [31:0] v_hlen;
	logic [31:0] v_type;

	logic        mem_we;
	logic        mem_re;
	logic [31:0] mem_rdata;

	result_t res;
	logic    emit;
	logic    out_free;

	logic        accept;
	logic        exec_hdr;
	logic        exec_body;
	logic        begin_body;
	logic        store_type;
	logic        body_active;
	logic [31:0] rem_next;
	logic        numeric;
	logic [63:0] val_shift;
	logic        col_end;
	logic        cols_left;
	logic [31:0] rd_len;
	logic        drain_load;
	logic        drain_emit;
	logic        trunc_emit;
	logic        eor_emit;
	logic        byte_trunc;
	logic [31:0] cur_len;

	dbrcd_varint u_varint (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (vctl),
		.byte_in  (byte_q),
		.done     (v_done),
		.hlen_sat (v_hlen),
		.type_sat (v_type)
	);

	dbrcd_type_mem #(
		.DEPTH  (MAX_COLUMNS),
		.ADDR_W (ADDR_W)
	) u_type_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (column_count_q[ADDR_W-1:0]),
		.wdata (v_type),
		.re    (mem_re),
		.raddr (cur_col_q[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	dbrcd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	assign accept      = s_tvalid && s_tready;
	assign exec_hdr    = (state_q == ST_EXEC) && (phase_q != PH_BODY);
	assign exec_body   = (state_q == ST_EXEC) && (phase_q == PH_BODY) && out_free;
	assign cols_left   = (cur_col_q < column_count_q);
	assign body_active = cols_left && (body_rem_q != '0);
	assign rem_next    = body_rem_q - 32'd1;
	assign numeric     = (cur_type_q[31:3] == '0) && (cur_type_q[2:0] != 3'd0);
	assign val_shift   = {value_acc_q[55:0], byte_q};
	assign col_end     = exec_body && body_active && (rem_next == '0);
	assign cur_len     = body_len(cur_type_q);
	assign rd_len      = body_len(mem_rdata);
	assign byte_trunc  = last_q && (rem_next != '0);

	// A header length not beyond the bytes already read leaves no room for types.
	always_comb begin
		begin_body = 1'b0;
		if (exec_hdr) begin
			if (phase_q == PH_HLEN) begin
				begin_body = v_done && (byte_position_q >= v_hlen);
			end else begin
				begin_body = (byte_position_q >= header_length_q);
			end
		end
	end

	assign store_type = exec_hdr && (phase_q == PH_TYPES) && v_done;
	assign mem_we     = store_type && (column_count_q < MAX_COLS);
	assign vctl.feed  = exec_hdr;
	assign vctl.clr   = (exec_hdr && begin_body) || eor_emit;

	assign drain_load = (state_q == ST_DRAIN_EV) && (rd_len != '0);
	assign drain_emit = (state_q == ST_DRAIN_EV) && (rd_len == '0) && out_free;
	assign trunc_emit = (state_q == ST_TRUNC) && cols_left && out_free;
	assign eor_emit   = (state_q == ST_EOR) && out_free;

	assign s_tready = (state_q == ST_IN);

	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		mem_re  = 1'b0;
		res     = '0;
		case (state_q)
			ST_IN: begin
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (phase_q != PH_BODY) begin
					if (begin_body) begin
						state_d = ST_DRAIN_RD;
					end else begin
						state_d = last_q ? ST_FIN : ST_IN;
					end
				end else if (out_free) begin
					res.col = cur_col_q[4:0];
					if (body_active && numeric) begin
						emit      = (rem_next == '0);
						res.kind  = (cur_type_q == ST_FLOAT) ? KIND_FLOAT : KIND_INT;
						res.value = sign_ext(val_shift, cur_len[3:0]);
						res.cd    = 1'b1;
					end else if (body_active) begin
						// A content byte cut off by the record end carries the truncation mark.
						emit     = 1'b1;
						res.kind = byte_trunc ? KIND_TRUNC
						                      : (cur_type_q[0] ? KIND_TEXT : KIND_BLOB);
						res.data = byte_q;
						res.bv   = 1'b1;
						res.cd   = (rem_next == '0) || last_q;
					end
					if (col_end) begin
						state_d = ST_DRAIN_RD;
					end else begin
						state_d = last_q ? ST_FIN : ST_IN;
					end
				end
			end
			ST_DRAIN_RD: begin
				if (cols_left) begin
					mem_re  = 1'b1;
					state_d = ST_DRAIN_EV;
				end else begin
					state_d = last_q ? ST_FIN : ST_IN;
				end
			end
			ST_DRAIN_EV: begin
				res.col = cur_col_q[4:0];
				res.cd  = 1'b1;
				if (rd_len != '0) begin
					state_d = last_q ? ST_FIN : ST_IN;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = ST_DRAIN_RD;
					if (mem_rdata == ST_NULL) begin
						res.kind = KIND_NULL;
					end else if (mem_rdata == ST_ZERO) begin
						res.kind = KIND_INT;
					end else if (mem_rdata == ST_ONE) begin
						res.kind  = KIND_INT;
						res.value = 64'd1;
					end else if (mem_rdata == ST_RES10 || mem_rdata == ST_RES11) begin
						res.kind  = KIND_RESERVED;
						res.value = {32'd0, mem_rdata};
					end else begin
						res.kind = mem_rdata[0] ? KIND_TEXT : KIND_BLOB;
					end
				end
			end
			ST_FIN: begin
				state_d = ST_TRUNC;
			end
			ST_TRUNC: begin
				res.col  = cur_col_q[4:0];
				res.kind = KIND_TRUNC;
				res.cd   = 1'b1;
				if (!cols_left) begin
					state_d = ST_EOR;
				end else if (out_free) begin
					emit = 1'b1;
				end
			end
			ST_EOR: begin
				res.kind  = KIND_EOR;
				res.value = {62'd0, (phase_q != PH_BODY), overflow_q};
				res.rd    = 1'b1;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IN;
				end
			end
			default: begin
				state_d = ST_IN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IN;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HLEN;
			header_length_q <= '0;
			byte_position_q <= '0;
			column_count_q  <= '0;
			cur_col_q       <= '0;
			body_rem_q      <= '0;
			value_acc_q     <= '0;
			overflow_q      <= 1'b0;
			cur_type_q      <= '0;
			byte_q          <= '0;
			last_q          <= 1'b0;
			trunc_byte_q    <= 1'b0;
		end else begin
			if (accept) begin
				byte_q <= s_tdata;
				last_q <= s_tlast;
				if (byte_position_q != 32'hFFFF_FFFF) begin
					byte_position_q <= byte_position_q + 32'd1;
				end
			end
			if (exec_hdr && (phase_q == PH_HLEN) && v_done) begin
				header_length_q <= v_hlen;
			end
			if (store_type) begin
				if (column_count_q < MAX_COLS) begin
					column_count_q <= column_count_q + 1'b1;
				end else begin
					overflow_q <= 1'b1;
				end
			end
			if (exec_hdr && begin_body) begin
				phase_q   <= PH_BODY;
				cur_col_q <= '0;
			end else if (exec_hdr && (phase_q == PH_HLEN) && v_done) begin
				phase_q <= PH_TYPES;
			end
			if (exec_body) begin
				trunc_byte_q <= body_active && !numeric && byte_trunc;
				if (body_active) begin
					body_rem_q <= rem_next;
					if (numeric) begin
						value_acc_q <= val_shift;
					end
					if (rem_next == '0) begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
			end
			if (drain_load) begin
				body_rem_q  <= rd_len;
				value_acc_q <= '0;
				cur_type_q  <= mem_rdata;
			end
			if (drain_emit || trunc_emit) begin
				cur_col_q <= cur_col_q + 1'b1;
			end
			// Truncation reports start after a column whose byte already took the mark,
			// and cover every stored column when the header never finished.
			if (state_q == ST_FIN) begin
				if (phase_q != PH_BODY) begin
					cur_col_q <= '0;
				end else if (trunc_byte_q) begin
					cur_col_q <= cur_col_q + 1'b1;
				end
			end
			if (eor_emit) begin
				phase_q         <= PH_HLEN;
				header_length_q <= '0;
				byte_position_q <= '0;
				column_count_q  <= '0;
				cur_col_q       <= '0;
				body_rem_q      <= '0;
				value_acc_q     <= '0;
				overflow_q      <= 1'b0;
				trunc_byte_q    <= 1'b0;
			end
		end
	end

	`DBRCD_ASSERT(a_count_bound, column_count_q <= MAX_COLS, "column count beyond store depth")
	`DBRCD_ASSERT_IMP(a_emit_free, emit, out_free, "result loaded over an untaken result")
	`DBRCD_ASSERT_IMP(a_rem_body, body_rem_q != '0, phase_q == PH_BODY, "body count outside body")
	`DBRCD_ASSERT_NXT(a_eor_clear, eor_emit, column_count_q == '0 && phase_q == PH_HLEN, "record state not cleared")

endmodule

// ----- test/tb_db_record_column_decoder.sv -----
// Self-checking testbench for the record column decoder: directed records, then random records.
`timescale 1ns / 1ps

module tb_db_record_column_decoder;
	import dbrcd_pkg::*;

	localparam int MAX_COLS = 32;

	typedef struct packed {
		logic [7:0]  rec_byte;
		logic        rec_last;
		logic        has_exp;
		logic [3:0]  at;
		kind_t       kind;
		logic [63:0] value;
	} directed_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = 8'd0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;

	// Decoder state as the predictor sees it.
	phase_t      dec_phase;
	logic [63:0] vi_acc;
	logic [3:0]  vi_cnt;
	logic [31:0] hdr_len;
	logic [31:0] pos;
	logic [31:0] col_types [MAX_COLS];
	logic [5:0]  n_cols;
	logic [5:0]  cur_col;
	logic [31:0] bytes_left;
	logic [63:0] val_acc;
	logic        ovf;

	result_t       step_results[$];
	result_t       pending_results[$];
	logic [7:0]    rec_bytes[$];
	directed_row_t directed_rows [0:25];

	int n_fail = 0;
	int n_items = 0;
	int n_records = 0;
	int n_results = 0;
	int n_trunc = 0;
	int n_ovf = 0;
	bit gappy = 1'b1;
	logic hold_req = 1'b0;
	logic quiet = 1'b0;

	db_record_column_decoder #(.MAX_COLUMNS(MAX_COLS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [31:0] content_len(input logic [31:0] t);
		if (t != ST_NULL && t < ST_INT48) return t;
		if (t == ST_INT48) return 32'd6;
		if (t == ST_INT64 || t == ST_FLOAT) return 32'd8;
		if (t >= ST_VAR_MIN) return (t - ST_VAR_MIN) >> 1;
		return 32'd0;
	endfunction

	function automatic void clear_decoder();
		dec_phase = PH_HLEN;
		vi_acc = '0;
		vi_cnt = '0;
		hdr_len = '0;
		pos = '0;
		foreach (col_types[i]) col_types[i] = '0;
		n_cols = '0;
		cur_col = '0;
		bytes_left = '0;
		val_acc = '0;
		ovf = 1'b0;
	endfunction

	// Returns 1 once the varint is complete; the ninth byte counts all eight bits.
	function automatic bit feed_varint(input logic [7:0] b);
		if (vi_cnt >= 4'd8) begin
			vi_acc = {vi_acc[55:0], b};
			return 1'b1;
		end
		vi_acc = {vi_acc[56:0], b[6:0]};
		vi_cnt++;
		return !b[7];
	endfunction

	function automatic void note_result(input logic [5:0] col, input kind_t k,
			input logic [63:0] v, input logic [7:0] d, input logic bv, input logic cd,
			input logic rd);
		result_t r;
		r.col = col[4:0];
		r.kind = k;
		r.value = v;
		r.data = d;
		r.bv = bv;
		r.cd = cd;
		r.rd = rd;
		step_results.insert(step_results.size(), r);
	endfunction

	// Emits every column that needs no body byte and loads the first one that does.
	function automatic void drain_empty_columns();
		logic [31:0] t;
		logic [31:0] len;
		while (cur_col < n_cols) begin
			t = col_types[cur_col];
			len = content_len(t);
			if (len != 0) begin
				bytes_left = len;
				val_acc = '0;
				return;
			end
			if (t == ST_NULL) begin
				note_result(cur_col, KIND_NULL, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0);
			end else if (t == ST_ZERO) begin
				note_result(cur_col, KIND_INT, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0);
			end else if (t == ST_ONE) begin
				note_result(cur_col, KIND_INT, 64'd1, 8'd0, 1'b0, 1'b1, 1'b0);
			end else if (t == ST_RES10 || t == ST_RES11) begin
				note_result(cur_col, KIND_RESERVED, {32'd0, t}, 8'd0, 1'b0, 1'b1, 1'b0);
			end else begin
				note_result(cur_col, t[0] ? KIND_TEXT : KIND_BLOB, 64'd0, 8'd0, 1'b0, 1'b1,
					1'b0);
			end
			cur_col++;
		end
	endfunction

	function automatic void enter_body();
		dec_phase = PH_BODY;
		vi_acc = '0;
		vi_cnt = '0;
		cur_col = '0;
		drain_empty_columns();
	endfunction

	// Works out the results of one accepted record byte and queues them.
	function automatic void decode_byte(input logic [7:0] b, input logic l,
			input logic has_exp, input logic [3:0] at, input kind_t k, input logic [63:0] v);
		int byte_slot;
		int bits;
		logic hdr_open;
		logic [31:0] t;
		logic [63:0] w;
		result_t r;
		step_results.delete();
		byte_slot = -1;
		if (pos != '1) pos++;
		case (dec_phase)
			PH_HLEN: begin
				if (feed_varint(b)) begin
					hdr_len = (vi_acc[63:32] != 0) ? '1 : vi_acc[31:0];
					vi_acc = '0;
					vi_cnt = '0;
					if (pos >= hdr_len) enter_body();
					else dec_phase = PH_TYPES;
				end
			end
			PH_TYPES: begin
				if (feed_varint(b)) begin
					t = (vi_acc[63:32] != 0) ? {31'h7FFF_FFFF, vi_acc[0]} : vi_acc[31:0];
					if (n_cols < MAX_COLS) begin
						col_types[n_cols] = t;
						n_cols++;
					end else begin
						ovf = 1'b1;
					end
					vi_acc = '0;
					vi_cnt = '0;
				end
				if (pos >= hdr_len) enter_body();
			end
			default: begin
				if (cur_col < n_cols && bytes_left != 0) begin
					t = col_types[cur_col];
					bytes_left--;
					if (t != ST_NULL && t <= ST_FLOAT) begin
						val_acc = {val_acc[55:0], b};
						if (bytes_left == 0) begin
							w = val_acc;
							bits = 8 * int'(content_len(t));
							if (bits < 64 && w[bits-1]) w |= ~((64'd1 << bits) - 64'd1);
							note_result(cur_col, (t == ST_FLOAT) ? KIND_FLOAT : KIND_INT, w,
								8'd0, 1'b0, 1'b1, 1'b0);
						end
					end else begin
						byte_slot = step_results.size();
						note_result(cur_col, t[0] ? KIND_TEXT : KIND_BLOB, 64'd0, b, 1'b1,
							bytes_left == 0, 1'b0);
					end
					if (bytes_left == 0) begin
						byte_slot = -1;
						cur_col++;
						drain_empty_columns();
					end
				end
			end
		endcase
		if (l) begin
			hdr_open = (dec_phase != PH_BODY);
			// A content byte of the column cut short becomes its truncation result.
			for (int c = hdr_open ? 0 : int'(cur_col); c < n_cols; c++) begin
				if (!hdr_open && c == cur_col && byte_slot >= 0) begin
					r = step_results[byte_slot];
					r.kind = KIND_TRUNC;
					r.cd = 1'b1;
					step_results[byte_slot] = r;
				end else begin
					note_result(6'(c), KIND_TRUNC, 64'd0, 8'd0, 1'b0, 1'b1, 1'b0);
				end
			end
			note_result(6'd0, KIND_EOR, {62'd0, hdr_open, ovf}, 8'd0, 1'b0, 1'b0, 1'b1);
			clear_decoder();
		end
		if (has_exp) begin
			if (at < step_results.size()) begin
				r = step_results[at];
				r.kind = k;
				r.value = v;
				step_results[at] = r;
			end else begin
				$error("directed row at byte 0x%0h gives no result %0d", b, at);
				n_fail++;
			end
		end
		foreach (step_results[i]) pending_results.insert(pending_results.size(), step_results[i]);
	endfunction

	function automatic void push_varint(ref logic [7:0] q[$], input logic [63:0] v);
		int n;
		if (v[63:56] != 0) begin
			for (int i = 7; i >= 0; i--)
				q.insert(q.size(), 8'h80 | 8'((v >> (8 + 7 * i)) & 64'h7F));
			q.insert(q.size(), v[7:0]);
		end else begin
			n = 1;
			while (n < 8 && (v >> (7 * n)) != 0) n++;
			for (int i = n - 1; i >= 0; i--)
				q.insert(q.size(), 8'((v >> (7 * i)) & 64'h7F) | ((i != 0) ? 8'h80 : 8'h00));
		end
	endfunction

	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [63:0] pick_type(input bit empty_only);
		int r;
		if (empty_only) begin
			case ($urandom_range(0, 6))
				0: return ST_NULL;
				1: return ST_ZERO;
				2: return ST_ONE;
				3: return ST_RES10;
				4: return ST_RES11;
				5: return ST_VAR_MIN;
				default: return ST_VAR_MIN + 1;
			endcase
		end
		r = $urandom_range(0, 99);
		if (r < 10) return ST_NULL;
		if (r < 16) return ST_ZERO;
		if (r < 22) return ST_ONE;
		if (r < 26) return $urandom_range(0, 1) ? ST_RES10 : ST_RES11;
		if (r < 46) return $urandom_range(1, 6);
		if (r < 54) return ST_FLOAT;
		if (r < 90) return $urandom_range(12, 25);
		if (r < 95) return $urandom_range(26, 60);
		// Lengths far beyond the record, and types wider than 32 bits.
		case ($urandom_range(0, 2))
			0: return {32'd0, $urandom | 32'h0000_1000};
			1: return {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
			default: return {32'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Builds one record into rec_bytes: mostly well formed, some noise and broken headers.
	task automatic make_record(input bit full_store);
		logic [7:0]  type_bytes[$];
		logic [63:0] rec_types[$];
		logic [63:0] t64;
		logic [31:0] t32;
		logic [31:0] len;
		int shape;
		int ncol;
		int hlen;
		int nb;
		bit long_len;
		rec_bytes.delete();
		shape = $urandom_range(0, 99);
		if (!full_store && shape < 8) begin
			nb = $urandom_range(1, 6);
			repeat (nb) rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(0, 255)));
			return;
		end
		if (!full_store && shape < 11) begin
			// Header length as a nine-byte varint, far beyond 32 bits.
			repeat (8) rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(128, 255)));
			nb = $urandom_range(2, 4);
			repeat (nb) rec_bytes.insert(rec_bytes.size(), 8'($urandom_range(0, 255)));
			return;
		end
		ncol = full_store ? $urandom_range(33, 36) : $urandom_range(0, 6);
		for (int i = 0; i < ncol; i++) begin
			t64 = pick_type(full_store);
			rec_types.insert(rec_types.size(), t64);
			push_varint(type_bytes, t64);
		end
		long_len = ($urandom_range(0, 9) == 0);
		hlen = type_bytes.size() + (long_len ? 2 : 1);
		if (!full_store && $urandom_range(0, 9) == 0) hlen += int'($urandom_range(0, 6)) - 3;
		if (hlen < 0) hlen = 0;
		if (long_len) begin
			rec_bytes.insert(rec_bytes.size(), 8'h80 | 8'(hlen >> 7));
			rec_bytes.insert(rec_bytes.size(), 8'(hlen & 'h7F));
		end else begin
			push_varint(rec_bytes, hlen);
		end
		foreach (type_bytes[i]) rec_bytes.insert(rec_bytes.size(), type_bytes[i]);
		for (int i = 0; i < ncol && i < MAX_COLS; i++) begin
			t64 = rec_types[i];
			t32 = (t64[63:32] != 0) ? {31'h7FFF_FFFF, t64[0]} : t64[31:0];
			len = content_len(t32);
			if (len > 24) begin
				nb = $urandom_range(0, 8);
				repeat (nb) rec_bytes.insert(rec_bytes.size(), body_byte());
				break;
			end
			repeat (len) rec_bytes.insert(rec_bytes.size(), body_byte());
		end
		if ($urandom_range(0, 6) == 0) begin
			nb = $urandom_range(1, 4);
			while (nb > 0 && rec_bytes.size() > 1) begin
				rec_bytes.delete(rec_bytes.size() - 1);
				nb--;
			end
		end else if ($urandom_range(0, 9) == 0) begin
			nb = $urandom_range(1, 3);
			repeat (nb) rec_bytes.insert(rec_bytes.size(), body_byte());
		end
	endtask

	task automatic send_item(input logic [7:0] b, input logic l, input logic has_exp,
			input logic [3:0] at, input kind_t k, input logic [63:0] v);
		if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		do @(posedge clk); while (!s_tready);
		decode_byte(b, l, has_exp, at, k, v);
		n_items++;
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (m_tuser[2:0] == KIND_TRUNC) n_trunc++;
			if (m_tuser[2:0] == KIND_EOR && m_tdata[5]) n_ovf++;
			if (pending_results.size() == 0) begin
				$error("result for column %0d of kind %0d with nothing expected",
					m_tdata[4:0], m_tuser[2:0]);
				n_fail++;
			end else begin
				want = pending_results.pop_front();
				check_field("column_index", want.col, m_tdata[4:0]);
				check_field("kind", want.kind, m_tuser[2:0]);
				check_field("int_value", want.value, m_tdata[68:5]);
				check_field("data_byte", want.data, m_tdata[76:69]);
				check_field("byte_valid", want.bv, m_tuser[3]);
				check_field("column_done", want.cd, m_tdata[77]);
				check_field("record_done", want.rd, m_tlast);
			end
		end
	end

	// Receiver: random stall bursts, ready stretches, and one long hold-off.
	initial begin
		int stall_left = 0;
		int run_left = 0;
		int hold_left = 0;
		bit held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (quiet || run_left > 0) begin
				if (run_left > 0) run_left--;
				m_tready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case ($urandom_range(0, 7))
					0, 1: begin
						stall_left = $urandom_range(1, 13) - 1;
						m_tready <= 1'b0;
					end
					2: begin
						run_left = $urandom_range(20, 60);
						m_tready <= 1'b1;
					end
					default: m_tready <= 1'b1;
				endcase
			end
		end
	end

	initial begin
		int rec_no = 0;
		int waited = 0;
		clear_decoder();
		directed_rows = '{
			// Int8, null, both constants and both reserved types, ending on the int byte.
			'{8'h07, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h01, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h00, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h08, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h09, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h0A, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h0B, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h80, 1'b1, 1'b1, 4'd0, KIND_INT, 64'hFFFF_FFFF_FFFF_FF80},
			// Float with all bits set, then a two-byte blob cut after one byte.
			'{8'h03, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h07, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h10, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b0, 1'b1, 4'd0, KIND_FLOAT, 64'hFFFF_FFFF_FFFF_FFFF},
			'{8'h5A, 1'b1, 1'b1, 4'd0, KIND_TRUNC, 64'd0},
			// Record ending inside the header.
			'{8'h05, 1'b1, 1'b1, 4'd0, KIND_EOR, 64'd2},
			// Zero header length: the body starts at once with no columns.
			'{8'h00, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'hFF, 1'b1, 1'b1, 4'd0, KIND_EOR, 64'd0},
			// Two-byte header length, one stored type, cut in the header.
			'{8'h81, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h00, 1'b0, 1'b0, 4'd0, KIND_NULL, 64'd0},
			'{8'h09, 1'b1, 1'b1, 4'd1, KIND_EOR, 64'd2}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			send_item(directed_rows[i].rec_byte, directed_rows[i].rec_last,
				directed_rows[i].has_exp, directed_rows[i].at, directed_rows[i].kind,
				directed_rows[i].value);
			if (directed_rows[i].rec_last) n_records++;
		end
		while (n_items < 170) begin
			make_record(rec_no == 1 || $urandom_range(0, 24) == 0);
			if (rec_no == 0) hold_req <= 1'b1;
			gappy = ($urandom_range(0, 3) != 0);
			foreach (rec_bytes[j]) begin
				send_item(rec_bytes[j], j == rec_bytes.size() - 1, 1'b0, 4'd0, KIND_NULL, 64'd0);
				if (n_items >= 140) quiet <= 1'b1;
			end
			n_records++;
			rec_no++;
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			n_fail++;
		end
		$display("Fed %0d record bytes in %0d records and checked %0d results,",
			n_items, n_records, n_results);
		$display("of which %0d truncated columns and %0d ends of record with a full store.",
			n_trunc, n_ovf);
		if (n_fail == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
